// ===== src/tgp_pkg.sv =====
// Shared constants and types of the trilinear grid prolongation block.
package tgp_pkg;

   // Defaults of the top-level parameters
   localparam int DEF_MAX_SIDE   = 64;
   localparam int DEF_VALUE_BITS = 32;
   localparam int GHOST_LAYERS   = 1;

   // Fixed port widths
   localparam int SIZE_BITS      = 7;
   localparam int COORD_BITS     = 8;
   localparam int PORT_VALUE_BITS = 32;
   localparam int WIDE_BITS      = 64;
   localparam int CSR_INDEX_BITS = 2;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIZE_Z = 2'd2;
   localparam logic [SIZE_BITS-1:0]      SIZE_RESET = 7'd8;

   // Taps of one coarse cell handed from fetch to emit (c111 only enters the
   // previous-plane sum)
   localparam int TAP_000  = 0;
   localparam int TAP_001  = 1;
   localparam int TAP_010  = 2;
   localparam int TAP_011  = 3;
   localparam int TAP_100  = 4;
   localparam int TAP_101  = 5;
   localparam int TAP_110  = 6;
   localparam int NUM_TAPS = 7;

   // Order of the eight results of one coarse cell
   localparam logic [2:0] RES_COPY     = 3'd0;
   localparam logic [2:0] RES_MEAN_Z   = 3'd1;
   localparam logic [2:0] RES_MEAN_Y   = 3'd2;
   localparam logic [2:0] RES_MEAN_X   = 3'd3;
   localparam logic [2:0] RES_MEAN_YZ  = 3'd4;
   localparam logic [2:0] RES_MEAN_XZ  = 3'd5;
   localparam logic [2:0] RES_MEAN_XY  = 3'd6;
   localparam logic [2:0] RES_MEAN_XYZ = 3'd7;

   // Clamped grid size in coarse cells per axis
   typedef struct packed {
      logic [SIZE_BITS-1:0] x;
      logic [SIZE_BITS-1:0] y;
      logic [SIZE_BITS-1:0] z;
   } grid_size_type;

   // Per-cell control handed from fetch to emit
   typedef struct packed {
      logic [COORD_BITS-1:0] fine_x;
      logic [COORD_BITS-1:0] fine_y;
      logic [COORD_BITS-1:0] fine_z;
      logic                  grid_end;
   } cell_ctrl_type;

endpackage

// ===== src/trilinear_grid_prolongation.sv =====
// Top level of the trilinear grid prolongation block: size registers and wiring.
//
// Usage: coarse values enter on the req_ channel in raster order, x slowest and
// z fastest, ghost layer included: (sx+1)*(sy+1)*(sz+1) beats make one grid.
// A beat is taken at a clock edge where req_valid is high and req_stall low.
// Each interior coarse beat yields eight beats on the rsp_ channel: the copy,
// three 2-point, three 4-point and one 8-point mean, with fine coordinates;
// rsp_cell_last marks the eighth and rsp_grid_done the last beat of the grid.
// Ghost beats are written into the plane memory and produce no result.
// The first result of a cell leaves the output register after the cell is gathered
// and taken by the emitter. A new interior coarse beat is taken once the emitter
// has taken the previous cell; the single output register emits one result per
// cycle while rsp_stall is low, and ghost beats are taken every cycle while no
// cell is gathered or held. Neighbor gathering takes four read pairs on the two
// ping-pong plane memories and overlaps the emission of the previous cell.
// rsp_stall holds the output register; the emitter and then req_stall follow.
// Sizes are written on the csr_ channel while the block is idle; a write to
// any size register restarts the grid at the origin. Reset clears positions
// and sets all sizes to 8; the plane memories need no clearing pass.
module trilinear_grid_prolongation #(
   parameter int MAX_SIDE   = tgp_pkg::DEF_MAX_SIDE,
   parameter int VALUE_BITS = tgp_pkg::DEF_VALUE_BITS
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic signed [tgp_pkg::PORT_VALUE_BITS-1:0]  req_coarse_value,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic signed [tgp_pkg::PORT_VALUE_BITS-1:0]  rsp_fine_value,
   output logic [tgp_pkg::COORD_BITS-1:0]              rsp_fine_x,
   output logic [tgp_pkg::COORD_BITS-1:0]              rsp_fine_y,
   output logic [tgp_pkg::COORD_BITS-1:0]              rsp_fine_z,
   output logic                                        rsp_cell_last,
   output logic                                        rsp_grid_done,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [tgp_pkg::CSR_INDEX_BITS-1:0]          csr_index,
   input  logic [tgp_pkg::SIZE_BITS-1:0]               csr_data
);

   localparam int SB = tgp_pkg::SIZE_BITS;

   logic [SB-1:0] size_x_ff, size_x_in, size_y_ff, size_y_in, size_z_ff, size_z_in;
   logic          restart;
   logic          csr_write;
   tgp_pkg::grid_size_type sizes;
   logic [tgp_pkg::WIDE_BITS-1:0] in_wide;
   logic [VALUE_BITS-1:0]         in_value;

   logic          cell_valid;
   logic          cell_take;
   logic [tgp_pkg::NUM_TAPS-1:0][VALUE_BITS-1:0] cell_taps;
   logic signed [VALUE_BITS+1:0] cell_prev_sum;
   tgp_pkg::cell_ctrl_type       cell_ctrl;

   // Size zero counts as one, sizes beyond MAX_SIDE count as MAX_SIDE
   function automatic logic [SB-1:0] clamp_size(input logic [SB-1:0] s);
      logic [SB-1:0] r;
      r = s;
      if (s == '0) begin
         r = SB'(1);
      end else if (32'(s) > MAX_SIDE) begin
         r = SB'(MAX_SIDE);
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Size register writes; a valid index restarts the grid
   always_comb begin
      size_x_in = size_x_ff;
      size_y_in = size_y_ff;
      size_z_in = size_z_ff;
      restart   = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            tgp_pkg::CSR_SIZE_X: begin
               size_x_in = csr_data;
               restart   = 1'b1;
            end
            tgp_pkg::CSR_SIZE_Y: begin
               size_y_in = csr_data;
               restart   = 1'b1;
            end
            tgp_pkg::CSR_SIZE_Z: begin
               size_z_in = csr_data;
               restart   = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= tgp_pkg::SIZE_RESET;
         size_y_ff <= tgp_pkg::SIZE_RESET;
         size_z_ff <= tgp_pkg::SIZE_RESET;
      end else begin
         size_x_ff <= size_x_in;
         size_y_ff <= size_y_in;
         size_z_ff <= size_z_in;
      end
   end

   assign sizes.x = clamp_size(size_x_ff);
   assign sizes.y = clamp_size(size_y_ff);
   assign sizes.z = clamp_size(size_z_ff);

   // Take the low value bits of the port pattern
   assign in_wide  = tgp_pkg::WIDE_BITS'($unsigned(req_coarse_value));
   assign in_value = in_wide[VALUE_BITS-1:0];

   tgp_fetch #(
      .MAX_SIDE   (MAX_SIDE),
      .VALUE_BITS (VALUE_BITS)
   ) u_fetch (
      .clock         (clock),
      .reset         (reset),
      .sizes         (sizes),
      .restart       (restart),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .in_value      (in_value),
      .cell_valid    (cell_valid),
      .cell_take     (cell_take),
      .cell_taps     (cell_taps),
      .cell_prev_sum (cell_prev_sum),
      .cell_ctrl     (cell_ctrl)
   );

   tgp_emit #(
      .VALUE_BITS (VALUE_BITS)
   ) u_emit (
      .clock          (clock),
      .reset          (reset),
      .cell_valid     (cell_valid),
      .cell_take      (cell_take),
      .cell_taps      (cell_taps),
      .cell_prev_sum  (cell_prev_sum),
      .cell_ctrl      (cell_ctrl),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_fine_value (rsp_fine_value),
      .rsp_fine_x     (rsp_fine_x),
      .rsp_fine_y     (rsp_fine_y),
      .rsp_fine_z     (rsp_fine_z),
      .rsp_cell_last  (rsp_cell_last),
      .rsp_grid_done  (rsp_grid_done)
   );

endmodule

// ===== src/tgp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tgp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4225
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tgp_fetch.sv =====
// Raster tracking, ping-pong plane memories and gathering of one coarse cell.
module tgp_fetch #(
   parameter int MAX_SIDE   = tgp_pkg::DEF_MAX_SIDE,
   parameter int VALUE_BITS = tgp_pkg::DEF_VALUE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tgp_pkg::grid_size_type                sizes,
   input  logic                                  restart,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [VALUE_BITS-1:0]                 in_value,
   output logic                                  cell_valid,
   input  logic                                  cell_take,
   output logic [tgp_pkg::NUM_TAPS-1:0][VALUE_BITS-1:0] cell_taps,
   output logic signed [VALUE_BITS+1:0]          cell_prev_sum,
   output tgp_pkg::cell_ctrl_type                cell_ctrl
);

   localparam int PLANE_SIDE  = MAX_SIDE + tgp_pkg::GHOST_LAYERS;
   localparam int PLANE_DEPTH = PLANE_SIDE * PLANE_SIDE;
   localparam int ADDR_BITS   = $clog2(PLANE_DEPTH);
   localparam int PP_BITS     = VALUE_BITS + 2;
   localparam int SB          = tgp_pkg::SIZE_BITS;
   localparam logic [2:0] STEP_LAST = 3'd4;

   logic [SB-1:0]        x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic                 bank_ff, bank_in;
   logic                 busy_ff, busy_in;
   logic                 full_ff, full_in;
   logic [2:0]           step_ff, step_in;
   logic                 sel_ff, sel_in;
   logic [ADDR_BITS-1:0] base_ff, base_in;
   logic [tgp_pkg::NUM_TAPS-1:0][VALUE_BITS-1:0] taps_ff, taps_in;
   logic signed [PP_BITS-1:0] pp_ff, pp_in;
   tgp_pkg::cell_ctrl_type    ctrl_ff, ctrl_in;

   logic                 accept;
   logic                 interior;
   logic                 grid_end;
   logic [SB:0]          row;
   logic [ADDR_BITS-1:0] cur_addr, prev_addr;
   logic [ADDR_BITS-1:0] rd_addr0, rd_addr1;
   logic [VALUE_BITS-1:0] rd_data0, rd_data1;
   logic [VALUE_BITS-1:0] cur_data, prev_data;
   logic                 wr_en0, wr_en1;
   logic                 reading;

   assign accept    = req_valid && !busy_ff;
   assign req_stall = busy_ff;
   assign interior  = (x_ff != '0) && (y_ff != '0) && (z_ff != '0);
   assign grid_end  = (x_ff == sizes.x) && (y_ff == sizes.y) && (z_ff == sizes.z);
   assign row       = {1'b0, sizes.z} + (SB+1)'(1);
   assign reading   = busy_ff && !full_ff;

   // Advance raster position and plane address; swap planes at each plane end
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      addr_in = addr_ff;
      bank_in = bank_ff;
      if (restart) begin
         x_in    = '0;
         y_in    = '0;
         z_in    = '0;
         addr_in = '0;
      end else if (accept) begin
         addr_in = addr_ff + ADDR_BITS'(1);
         if (z_ff < sizes.z) begin
            z_in = z_ff + SB'(1);
         end else begin
            z_in = '0;
            if (y_ff < sizes.y) begin
               y_in = y_ff + SB'(1);
            end else begin
               y_in    = '0;
               addr_in = '0;
               bank_in = !bank_ff;
               x_in    = (x_ff < sizes.x) ? x_ff + SB'(1) : '0;
            end
         end
      end
   end

   // Sequence the cell gather: four read pairs, then hold until emit takes it
   always_comb begin
      busy_in = busy_ff;
      full_in = full_ff;
      step_in = step_ff;
      if (accept) begin
         busy_in = interior;
         full_in = 1'b0;
         step_in = '0;
      end else if (cell_take) begin
         busy_in = 1'b0;
         full_in = 1'b0;
      end else if (reading) begin
         step_in = step_ff + 3'd1;
         full_in = (step_ff == STEP_LAST);
      end
   end

   // Read addresses of each step, relative to the cell's own entry
   always_comb begin
      unique case (step_ff)
         3'd0: begin
            cur_addr  = base_ff - ADDR_BITS'(1);
            prev_addr = base_ff;
         end
         3'd1: begin
            cur_addr  = ADDR_BITS'(base_ff - row);
            prev_addr = base_ff - ADDR_BITS'(1);
         end
         3'd2: begin
            cur_addr  = ADDR_BITS'(base_ff - row - 1'b1);
            prev_addr = ADDR_BITS'(base_ff - row);
         end
         default: begin
            cur_addr  = ADDR_BITS'(base_ff - row - 1'b1);
            prev_addr = ADDR_BITS'(base_ff - row - 1'b1);
         end
      endcase
   end

   assign rd_addr0  = sel_ff ? prev_addr : cur_addr;
   assign rd_addr1  = sel_ff ? cur_addr : prev_addr;
   assign cur_data  = sel_ff ? rd_data1 : rd_data0;
   assign prev_data = sel_ff ? rd_data0 : rd_data1;
   assign wr_en0    = accept && !bank_ff;
   assign wr_en1    = accept && bank_ff;

   // Capture the new value on accept, then the neighbors as they return
   always_comb begin
      taps_in = taps_ff;
      pp_in   = pp_ff;
      sel_in  = sel_ff;
      base_in = base_ff;
      ctrl_in = ctrl_ff;
      if (accept) begin
         taps_in[tgp_pkg::TAP_000] = in_value;
         sel_in          = bank_ff;
         base_in         = addr_ff;
         ctrl_in.fine_x  = {x_ff, 1'b0};
         ctrl_in.fine_y  = {y_ff, 1'b0};
         ctrl_in.fine_z  = {z_ff, 1'b0};
         ctrl_in.grid_end = grid_end;
      end else if (reading) begin
         unique case (step_ff)
            3'd1: begin
               taps_in[tgp_pkg::TAP_001] = cur_data;
               taps_in[tgp_pkg::TAP_100] = prev_data;
               pp_in = PP_BITS'($signed(prev_data));
            end
            3'd2: begin
               taps_in[tgp_pkg::TAP_010] = cur_data;
               taps_in[tgp_pkg::TAP_101] = prev_data;
               pp_in = pp_ff + PP_BITS'($signed(prev_data));
            end
            3'd3: begin
               taps_in[tgp_pkg::TAP_011] = cur_data;
               taps_in[tgp_pkg::TAP_110] = prev_data;
               pp_in = pp_ff + PP_BITS'($signed(prev_data));
            end
            3'd4: begin
               pp_in = pp_ff + PP_BITS'($signed(prev_data));
            end
            default: begin
               pp_in = pp_ff;
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff    <= '0;
         y_ff    <= '0;
         z_ff    <= '0;
         addr_ff <= '0;
         bank_ff <= 1'b0;
         busy_ff <= 1'b0;
         full_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         addr_ff <= addr_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
         full_ff <= full_in;
         step_ff <= step_in;
      end
   end

   // Cell payload registers
   always_ff @(posedge clock) begin
      taps_ff <= taps_in;
      pp_ff   <= pp_in;
      sel_ff  <= sel_in;
      base_ff <= base_in;
      ctrl_ff <= ctrl_in;
   end

   tgp_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (PLANE_DEPTH)
   ) u_plane0 (
      .clock   (clock),
      .wr_en   (wr_en0),
      .wr_addr (addr_ff),
      .wr_data (in_value),
      .rd_addr (rd_addr0),
      .rd_data (rd_data0)
   );

   tgp_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (PLANE_DEPTH)
   ) u_plane1 (
      .clock   (clock),
      .wr_en   (wr_en1),
      .wr_addr (addr_ff),
      .wr_data (in_value),
      .rd_addr (rd_addr1),
      .rd_data (rd_data1)
   );

   assign cell_valid    = full_ff;
   assign cell_taps     = taps_ff;
   assign cell_prev_sum = pp_ff;
   assign cell_ctrl     = ctrl_ff;

`ifndef SYNTHESIS
   // No plane write while a cell is being gathered or held
   a_no_write_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !(wr_en0 || wr_en1))
      else $error("plane write during cell gather");

   // A gathered cell holds until emit takes it
   a_cell_holds: assert property (@(posedge clock) disable iff (reset)
      full_ff && !cell_take |=> full_ff && $stable(taps_ff) && $stable(pp_ff))
      else $error("gathered cell changed before hand-off");
`endif

endmodule

// ===== src/tgp_emit.sv =====
// Emission of the eight fine values of one coarse cell through an output register.
module tgp_emit #(
   parameter int VALUE_BITS = tgp_pkg::DEF_VALUE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  cell_valid,
   output logic                                  cell_take,
   input  logic [tgp_pkg::NUM_TAPS-1:0][VALUE_BITS-1:0] cell_taps,
   input  logic signed [VALUE_BITS+1:0]          cell_prev_sum,
   input  tgp_pkg::cell_ctrl_type                cell_ctrl,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [tgp_pkg::PORT_VALUE_BITS-1:0] rsp_fine_value,
   output logic [tgp_pkg::COORD_BITS-1:0]        rsp_fine_x,
   output logic [tgp_pkg::COORD_BITS-1:0]        rsp_fine_y,
   output logic [tgp_pkg::COORD_BITS-1:0]        rsp_fine_z,
   output logic                                  rsp_cell_last,
   output logic                                  rsp_grid_done
);

   localparam int SUM_BITS = VALUE_BITS + 3;
   localparam int CB       = tgp_pkg::COORD_BITS;

   logic                 busy_ff, busy_in;
   logic [2:0]           k_ff, k_in;
   logic [tgp_pkg::NUM_TAPS-1:0][VALUE_BITS-1:0] taps_ff, taps_in;
   logic signed [VALUE_BITS+1:0] pp_ff, pp_in;
   tgp_pkg::cell_ctrl_type       ctrl_ff, ctrl_in;
   logic signed [SUM_BITS-1:0]   pz_ff, pz_in, py_ff, py_in, q4_ff, q4_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [tgp_pkg::PORT_VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [CB-1:0]        rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   logic                 rsp_last_ff, rsp_last_in, rsp_done_ff, rsp_done_in;

   logic                 out_load;
   logic                 at_last;
   logic signed [SUM_BITS-1:0] t000, t001, t010, t011, t100, t101, t110, tpp;
   logic signed [SUM_BITS-1:0] op_a, op_b, op_c, sum;
   logic [1:0]           shift;
   logic signed [SUM_BITS-1:0] shifted;
   logic [VALUE_BITS-1:0] mean;
   logic [tgp_pkg::WIDE_BITS-1:0] mean_wide;
   logic [CB-1:0]        fx, fy, fz, fxm, fym, fzm;

   assign out_load  = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign at_last   = (k_ff == tgp_pkg::RES_MEAN_XYZ);
   assign cell_take = cell_valid && (!busy_ff || (out_load && at_last));

   assign t000 = SUM_BITS'($signed(taps_ff[tgp_pkg::TAP_000]));
   assign t001 = SUM_BITS'($signed(taps_ff[tgp_pkg::TAP_001]));
   assign t010 = SUM_BITS'($signed(taps_ff[tgp_pkg::TAP_010]));
   assign t011 = SUM_BITS'($signed(taps_ff[tgp_pkg::TAP_011]));
   assign t100 = SUM_BITS'($signed(taps_ff[tgp_pkg::TAP_100]));
   assign t101 = SUM_BITS'($signed(taps_ff[tgp_pkg::TAP_101]));
   assign t110 = SUM_BITS'($signed(taps_ff[tgp_pkg::TAP_110]));
   assign tpp  = SUM_BITS'(pp_ff);

   assign fx  = ctrl_ff.fine_x;
   assign fy  = ctrl_ff.fine_y;
   assign fz  = ctrl_ff.fine_z;
   assign fxm = fx - CB'(1);
   assign fym = fy - CB'(1);
   assign fzm = fz - CB'(1);

   // Select the operands, shift and coordinates of the current result;
   // the wider means reuse the pair sums saved on earlier results
   always_comb begin
      op_a        = t000;
      op_b        = '0;
      op_c        = '0;
      shift       = 2'd0;
      rsp_x_in    = fx;
      rsp_y_in    = fy;
      rsp_z_in    = fz;
      rsp_last_in = 1'b0;
      rsp_done_in = 1'b0;
      unique case (k_ff)
         tgp_pkg::RES_COPY: begin
            op_a = t000;
         end
         tgp_pkg::RES_MEAN_Z: begin
            op_b     = t001;
            shift    = 2'd1;
            rsp_z_in = fzm;
         end
         tgp_pkg::RES_MEAN_Y: begin
            op_b     = t010;
            shift    = 2'd1;
            rsp_y_in = fym;
         end
         tgp_pkg::RES_MEAN_X: begin
            op_b     = t100;
            shift    = 2'd1;
            rsp_x_in = fxm;
         end
         tgp_pkg::RES_MEAN_YZ: begin
            op_a     = pz_ff;
            op_b     = t010;
            op_c     = t011;
            shift    = 2'd2;
            rsp_y_in = fym;
            rsp_z_in = fzm;
         end
         tgp_pkg::RES_MEAN_XZ: begin
            op_a     = pz_ff;
            op_b     = t100;
            op_c     = t101;
            shift    = 2'd2;
            rsp_x_in = fxm;
            rsp_z_in = fzm;
         end
         tgp_pkg::RES_MEAN_XY: begin
            op_a     = py_ff;
            op_b     = t100;
            op_c     = t110;
            shift    = 2'd2;
            rsp_x_in = fxm;
            rsp_y_in = fym;
         end
         tgp_pkg::RES_MEAN_XYZ: begin
            op_a        = q4_ff;
            op_b        = tpp;
            shift       = 2'd3;
            rsp_x_in    = fxm;
            rsp_y_in    = fym;
            rsp_z_in    = fzm;
            rsp_last_in = 1'b1;
            rsp_done_in = ctrl_ff.grid_end;
         end
         default: begin
            op_a = t000;
         end
      endcase
   end

   // Exact sum, then floor by arithmetic shift
   assign sum          = op_a + op_b + op_c;
   assign shifted      = sum >>> shift;
   assign mean         = shifted[VALUE_BITS-1:0];
   assign mean_wide    = tgp_pkg::WIDE_BITS'(mean);
   assign rsp_value_in = mean_wide[tgp_pkg::PORT_VALUE_BITS-1:0];

   // Keep the partial sums for the wider means
   always_comb begin
      pz_in = pz_ff;
      py_in = py_ff;
      q4_in = q4_ff;
      if (out_load) begin
         if (k_ff == tgp_pkg::RES_MEAN_Z) begin
            pz_in = sum;
         end
         if (k_ff == tgp_pkg::RES_MEAN_Y) begin
            py_in = sum;
         end
         if (k_ff == tgp_pkg::RES_MEAN_YZ) begin
            q4_in = sum;
         end
      end
   end

   // Take a new cell when idle or as the last result of the current one leaves
   always_comb begin
      busy_in = busy_ff;
      k_in    = k_ff;
      taps_in = taps_ff;
      pp_in   = pp_ff;
      ctrl_in = ctrl_ff;
      if (cell_take) begin
         busy_in = 1'b1;
         k_in    = tgp_pkg::RES_COPY;
         taps_in = cell_taps;
         pp_in   = cell_prev_sum;
         ctrl_in = cell_ctrl;
      end else if (out_load) begin
         k_in = k_ff + 3'd1;
         if (at_last) begin
            busy_in = 1'b0;
         end
      end
   end

   // Output register: load a result, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         k_ff         <= tgp_pkg::RES_COPY;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      taps_ff <= taps_in;
      pp_ff   <= pp_in;
      ctrl_ff <= ctrl_in;
      pz_ff   <= pz_in;
      py_ff   <= py_in;
      q4_ff   <= q4_in;
      if (out_load) begin
         rsp_value_ff <= rsp_value_in;
         rsp_x_ff     <= rsp_x_in;
         rsp_y_ff     <= rsp_y_in;
         rsp_z_ff     <= rsp_z_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_done_ff  <= rsp_done_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fine_value = rsp_value_ff;
   assign rsp_fine_x     = rsp_x_ff;
   assign rsp_fine_y     = rsp_y_ff;
   assign rsp_fine_z     = rsp_z_ff;
   assign rsp_cell_last  = rsp_last_ff;
   assign rsp_grid_done  = rsp_done_ff;

`ifndef SYNTHESIS
   // Going idle happens only right after the eighth result of a cell loads
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> rsp_valid_ff && rsp_last_ff)
      else $error("emitter went idle before the last result of a cell");

   // End of grid is flagged only on the last result of a cell
   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> rsp_last_ff)
      else $error("grid end flagged on a result that does not close a cell");
`endif

endmodule
